[rtl/lnps_pkg.sv]
package lnps_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int KIND_W     = 2;
  localparam int RANK_W     = 8;

  localparam logic [RANK_W-1:0] RANK_NONE = '0;
  localparam logic [RANK_W-1:0] RANK_TOP  = RANK_W'(1);
  localparam logic [RANK_W-1:0] RANK_MAX  = '1;

  localparam logic REQ_NOTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [KIND_W-1:0] MSG_NOTE_ON  = 2'd0;
  localparam logic [KIND_W-1:0] MSG_NOTE_OFF = 2'd1;

  localparam logic [KIND_W-1:0] EV_BEGIN  = 2'd0;
  localparam logic [KIND_W-1:0] EV_END    = 2'd1;
  localparam logic [KIND_W-1:0] EV_CHANGE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic              apply;
    logic              press;
    logic [NOTE_W-1:0] note;
    logic [RANK_W-1:0] gone;
  } cell_cmd_t;

endpackage

[rtl/last_note_priority_stack.sv]
// channel | dir | tdata (low bit up)               | tuser (low bit up)
// s_axis  | in  | note_number, velocity, 2'b0      | req_type, message_kind
// m_axis  | out | note_id, new_note_id, 2'b0       | event_kind
//
// the transfer cycle reads the addressed note's rank and the top note out of
// the cell row; in the busy state that follows, all cells update at once or
// the event is formed
// reset clears every rank cell and the reported note
// a tick waits in the busy state while the output register is full and not being taken
module last_note_priority_stack (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // note_number[6:0], velocity[13:7], zero pad
  input  logic [2:0]  s_axis_tuser,  // req_type[0], message_kind[2:1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // note_id[6:0], new_note_id[13:7], zero pad
  output logic [1:0]  m_axis_tuser   // event_kind[1:0]
);
  import lnps_pkg::*;

  state_t            state;
  state_t            state_next;
  logic              accept;
  logic              load_out;

  logic [NOTE_W-1:0] in_note;
  logic [VEL_W-1:0]  in_vel;
  logic              in_req;
  logic [KIND_W-1:0] in_kind;
  logic              in_range;

  logic [RANK_W-1:0] ranks [NOTE_COUNT];
  logic [RANK_W-1:0] note_rank;
  logic              top_found;
  logic [NOTE_W-1:0] top_note;

  logic              is_tick;
  logic              msg_apply;
  logic              msg_press;
  logic [NOTE_W-1:0] msg_note;
  logic [RANK_W-1:0] gone;
  logic              cur_found;
  logic [NOTE_W-1:0] cur_note;
  logic              reported_valid;
  logic [NOTE_W-1:0] reported_note;
  logic              differ;
  cell_cmd_t         cmd;

  assign in_note  = s_axis_tdata[NOTE_W-1:0];
  assign in_vel   = s_axis_tdata[NOTE_W+VEL_W-1:NOTE_W];
  assign in_req   = s_axis_tuser[0];
  assign in_kind  = s_axis_tuser[KIND_W:1];
  assign in_range = ({1'b0, in_note} < (NOTE_W+1)'(NOTE_COUNT));
  assign accept   = s_axis_tvalid && s_axis_tready;

  lnps_gather u_gather (
    .ranks     (ranks),
    .note      (in_note),
    .note_rank (note_rank),
    .top_found (top_found),
    .top_note  (top_note)
  );

  assign cmd.apply = (state == ST_BUSY) && !is_tick && msg_apply;
  assign cmd.press = msg_press;
  assign cmd.note  = msg_note;
  assign cmd.gone  = gone;

  for (genvar i = 0; i < NOTE_COUNT; i++) begin : g_cell
    lnps_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .idx  (NOTE_W'(i)),
      .cmd  (cmd),
      .rank (ranks[i])
    );
  end

  assign differ = (cur_found != reported_valid) ||
                  (cur_found && cur_note != reported_note);

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (!is_tick) begin
          state_next = ST_IDLE;
        end else if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = differ;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      is_tick   <= (in_req == REQ_TICK);
      msg_apply <= in_range && (in_kind == MSG_NOTE_ON || in_kind == MSG_NOTE_OFF);
      msg_press <= (in_kind == MSG_NOTE_ON) && (in_vel != '0);
      msg_note  <= in_note;
      gone      <= note_rank;
      cur_found <= top_found;
      cur_note  <= top_note;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reported_valid <= 1'b0;
      reported_note  <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (load_out) begin
        m_axis_tvalid  <= 1'b1;
        reported_valid <= cur_found;
        reported_note  <= cur_found ? cur_note : '0;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (!reported_valid) begin
        m_axis_tuser <= EV_BEGIN;
        m_axis_tdata <= {2'b00, NOTE_W'(0), cur_note};
      end else if (!cur_found) begin
        m_axis_tuser <= EV_END;
        m_axis_tdata <= {2'b00, NOTE_W'(0), reported_note};
      end else begin
        m_axis_tuser <= EV_CHANGE;
        m_axis_tdata <= {2'b00, cur_note, reported_note};
      end
    end
  end

endmodule

[rtl/lnps_cell.sv]
module lnps_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lnps_pkg::NOTE_W-1:0] idx,
  input  lnps_pkg::cell_cmd_t       cmd,
  output logic [lnps_pkg::RANK_W-1:0] rank
);
  import lnps_pkg::*;

  logic              hit;
  logic [RANK_W-1:0] base;
  logic [RANK_W-1:0] rank_next;

  assign hit = (cmd.note == idx);

  always_comb begin
    // close the gap left by the old rank of the addressed note
    if (cmd.gone != RANK_NONE && rank > cmd.gone) begin
      base = rank - RANK_TOP;
    end else begin
      base = rank;
    end
    rank_next = rank;
    if (cmd.apply) begin
      if (hit) begin
        rank_next = cmd.press ? RANK_TOP : RANK_NONE;
      end else if (rank != RANK_NONE) begin
        if (cmd.press && base != RANK_MAX) begin
          rank_next = base + RANK_TOP;
        end else begin
          rank_next = base;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= RANK_NONE;
    end else begin
      rank <= rank_next;
    end
  end

endmodule

[rtl/lnps_gather.sv]
module lnps_gather (
  input  logic [lnps_pkg::RANK_W-1:0] ranks [lnps_pkg::NOTE_COUNT],
  input  logic [lnps_pkg::NOTE_W-1:0] note,
  output logic [lnps_pkg::RANK_W-1:0] note_rank,
  output logic                        top_found,
  output logic [lnps_pkg::NOTE_W-1:0] top_note
);
  import lnps_pkg::*;

  // ranks are unique, so plain or-reductions act as one-hot selects
  always_comb begin
    note_rank = '0;
    top_found = 1'b0;
    top_note  = '0;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      if (note == NOTE_W'(i)) begin
        note_rank = note_rank | ranks[i];
      end
      if (ranks[i] == RANK_TOP) begin
        top_found = 1'b1;
        top_note  = top_note | NOTE_W'(i);
      end
    end
  end

endmodule

[rtl/lnps_checker.sv]
module lnps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import lnps_pkg::*;

  // one item at a time
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // a new result only follows a tick transfer
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready &&
                                   s_axis_tuser[0] == REQ_TICK, 2))
    else $error("result without a tick");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == EV_BEGIN || m_axis_tuser == EV_END ||
                       m_axis_tuser == EV_CHANGE))
    else $error("bad event code");

  a_single_note_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != EV_CHANGE |-> m_axis_tdata[15:7] == '0)
    else $error("second note field set outside a change");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
                                        $stable(m_axis_tuser))
    else $error("output transfer dropped or changed while stalled");

endmodule

bind last_note_priority_stack lnps_checker u_lnps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[dv/last_note_priority_stack_tb.sv]
`timescale 1ns / 100ps
module last_note_priority_stack_tb;
  import lnps_pkg::*;

  localparam logic [KIND_W-1:0] MSG_OTHER = 2'd2;
  localparam logic [KIND_W-1:0] MSG_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 700;
  localparam int MAX_GAP      = 5;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NOTE_W-1:0] note_id;
    logic [NOTE_W-1:0] new_note_id;
  } voice_evt_t;

  class voice_tracker;
    logic [RANK_W-1:0] rank [NOTE_COUNT];
    logic              sounding;
    logic [NOTE_W-1:0] sounding_note;
    voice_evt_t        pending_events[$];
    int                mismatches;

    function new();
      foreach (rank[i]) rank[i] = RANK_NONE;
      sounding      = 1'b0;
      sounding_note = '0;
      mismatches    = 0;
    endfunction

    function void lift_note(int n);
      logic [RANK_W-1:0] gone;
      gone = rank[n];
      if (gone == RANK_NONE) return;
      rank[n] = RANK_NONE;
      foreach (rank[i]) if (rank[i] > gone) rank[i] = rank[i] - 1'b1;
    endfunction

    function void strike_note(int n);
      lift_note(n);
      foreach (rank[i]) begin
        if (rank[i] != RANK_NONE && rank[i] != RANK_MAX) rank[i] = rank[i] + 1'b1;
      end
      rank[n] = RANK_TOP;
    endfunction

    function void note_transfer(logic req, logic [KIND_W-1:0] kind,
                                logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
      logic              held;
      logic [NOTE_W-1:0] top;
      voice_evt_t        ev;
      held = 1'b0;
      top  = '0;
      if (req == REQ_NOTE) begin
        if (int'(note) >= NOTE_COUNT) return;
        if (kind == MSG_NOTE_ON && vel != '0) strike_note(note);
        else if (kind == MSG_NOTE_ON || kind == MSG_NOTE_OFF) lift_note(note);
        return;
      end
      // lowest note holding the top rank
      for (int i = NOTE_COUNT - 1; i >= 0; i--) begin
        if (rank[i] == RANK_TOP) begin
          held = 1'b1;
          top  = NOTE_W'(i);
        end
      end
      if (held == sounding && (!held || top == sounding_note)) return;
      if (!sounding) ev = '{EV_BEGIN, top, '0};
      else if (!held) ev = '{EV_END, sounding_note, '0};
      else ev = '{EV_CHANGE, sounding_note, top};
      pending_events.push_back(ev);
      sounding      = held;
      sounding_note = held ? top : '0;
    endfunction

    function void report(string what, voice_evt_t want, voice_evt_t got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch %s: exp kind=%0d note=%0d new=%0d got kind=%0d note=%0d new=%0d",
                 what, want.kind, want.note_id, want.new_note_id,
                 got.kind, got.note_id, got.new_note_id);
    endfunction

    function void check_event(voice_evt_t got);
      voice_evt_t want;
      if (pending_events.size() == 0) begin
        report("no event expected", '0, got);
        return;
      end
      want = pending_events.pop_front();
      if (got.kind != want.kind) report("event_kind", want, got);
      if (got.note_id != want.note_id) report("note_id", want, got);
      if (got.new_note_id != want.new_note_id) report("new_note_id", want, got);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  voice_tracker sb;
  bit           tx_burst = 1'b0;
  bit           rx_burst = 1'b0;
  int           cycles = 0;

  last_note_priority_stack u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result transfers
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_event('{m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[13:7]});
  end

  // output back-pressure
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!m_axis_tvalid) @(posedge clk);
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  task automatic send_item(logic req, logic [KIND_W-1:0] kind,
                           logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, vel, note};
    s_axis_tuser  <= {kind, req};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_transfer(req, kind, note, vel);
  endtask

  initial begin
    int                pool [8];
    int                r;
    int                held_notes[$];
    bit                press_heavy;
    logic [NOTE_W-1:0] n;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // tick with nothing held, stray tick fields
    send_item(REQ_TICK, MSG_SPARE, 7'd127, 7'd127);
    send_item(REQ_NOTE, MSG_NOTE_ON, 7'd0, 7'd127);
    send_item(REQ_TICK, MSG_NOTE_ON, 7'd0, 7'd0);
    send_item(REQ_NOTE, MSG_NOTE_ON, 7'd127, 7'd1);
    send_item(REQ_NOTE, MSG_OTHER, 7'd0, 7'd0);
    send_item(REQ_NOTE, MSG_SPARE, 7'd127, 7'd127);
    send_item(REQ_TICK, MSG_OTHER, 7'd85, 7'd42);
    send_item(REQ_TICK, MSG_NOTE_OFF, 7'd42, 7'd85);
    // re-press of a held note
    send_item(REQ_NOTE, MSG_NOTE_ON, 7'd0, 7'd64);
    send_item(REQ_TICK, MSG_NOTE_ON, 7'd0, 7'd0);
    send_item(REQ_NOTE, MSG_NOTE_OFF, 7'd0, 7'd127);
    // release of an unheld note
    send_item(REQ_NOTE, MSG_NOTE_OFF, 7'd5, 7'd0);
    send_item(REQ_NOTE, MSG_NOTE_ON, 7'd127, 7'd0);
    send_item(REQ_TICK, MSG_NOTE_ON, 7'd0, 7'd0);
    send_item(REQ_NOTE, MSG_NOTE_ON, 7'd85, 7'd42);
    send_item(REQ_NOTE, MSG_NOTE_ON, 7'd42, 7'd85);
    send_item(REQ_NOTE, MSG_NOTE_OFF, 7'd85, 7'd1);
    send_item(REQ_TICK, MSG_NOTE_ON, 7'd0, 7'd0);
    send_item(REQ_NOTE, MSG_NOTE_ON, 7'd42, 7'd0);
    send_item(REQ_TICK, MSG_NOTE_ON, 7'd0, 7'd0);

    foreach (pool[k]) pool[k] = $urandom_range(0, NOTE_COUNT - 1);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        pool[$urandom_range(0, 7)] = $urandom_range(0, NOTE_COUNT - 1);
      end
      press_heavy = ((i / 60) % 2 == 0);
      r = $urandom_range(0, 99);
      if (r < 22) begin
        send_item(REQ_TICK, KIND_W'($urandom_range(0, 3)), NOTE_W'($urandom_range(0, 127)),
                  VEL_W'($urandom_range(0, 127)));
      end else if (r < 26) begin
        send_item(REQ_NOTE, $urandom_range(0, 1) ? MSG_OTHER : MSG_SPARE,
                  NOTE_W'($urandom_range(0, 127)), VEL_W'($urandom_range(0, 127)));
      end else if (r < (press_heavy ? 72 : 45)) begin
        if ($urandom_range(0, 3) == 0) n = NOTE_W'($urandom_range(0, 127));
        else n = NOTE_W'(pool[$urandom_range(0, 7)]);
        send_item(REQ_NOTE, MSG_NOTE_ON, n, VEL_W'($urandom_range(1, 127)));
      end else begin
        held_notes.delete();
        foreach (sb.rank[k]) if (sb.rank[k] != RANK_NONE) held_notes.push_back(k);
        if (held_notes.size() > 0 && $urandom_range(0, 4) != 0)
          n = NOTE_W'(held_notes[$urandom_range(0, held_notes.size() - 1)]);
        else
          n = NOTE_W'($urandom_range(0, 127));
        if ($urandom_range(0, 1))
          send_item(REQ_NOTE, MSG_NOTE_OFF, n, VEL_W'($urandom_range(0, 127)));
        else send_item(REQ_NOTE, MSG_NOTE_ON, n, 7'd0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lnps_pkg.sv
rtl/lnps_cell.sv
rtl/lnps_gather.sv
rtl/last_note_priority_stack.sv
rtl/lnps_checker.sv
dv/last_note_priority_stack_tb.sv
